// ----- hdl/sorted_list_table_engine_core_macros.svh -----
// Assertion macros for the sorted list table engine.
// Included by modules that carry concurrent checks; uses clk_i and rst_ni of the includer.
`ifndef SORTED_LIST_TABLE_ENGINE_CORE_MACROS_SVH
`define SORTED_LIST_TABLE_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SLTE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SLTE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLTE_ASSERT(name, prop, msg)
`define SLTE_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ----- hdl/slte_pkg.sv -----
// Shared types and codes of the sorted list table engine.
// No dependencies; used by the engine top level.
package slte_pkg;

  localparam int unsigned DefCapacity = 64;

  localparam logic [2:0] CmdInsert  = 3'd0;
  localparam logic [2:0] CmdDelete  = 3'd1;
  localparam logic [2:0] CmdSearch  = 3'd2;
  localparam logic [2:0] CmdFwd     = 3'd3;
  localparam logic [2:0] CmdRev     = 3'd4;

  localparam logic [2:0] StDone     = 3'd0;
  localparam logic [2:0] StNotFound = 3'd1;
  localparam logic [2:0] StEmpty    = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StEntry    = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] item_value;
    logic [6:0]         position;
    logic               last;
  } rsp_t;

endpackage

// ----- hdl/slte_mem.sv -----
// Single-port-write, single-port-read entry memory with registered read data.
// Depends on nothing; instantiated by the engine top level.
module slte_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic signed [31:0]      wdata_i,
  input  logic [AddrW-1:0]        raddr_i,
  output logic signed [31:0]      rdata_o
);

  logic signed [31:0] mem [Depth];
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/sorted_list_table_engine_core.sv -----
// Top level of the sorted list table engine: command sequencer and output register.
// Depends on slte_pkg, slte_mem and the assertion macro header.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   slte_pkg::req_t in_data_i
//   out       output     out_valid_o/out_ready_i slte_pkg::rsp_t out_data_o
//
// Insert, delete and search scan one entry per cycle; insert and delete then shift one entry per cycle.
// Traverse emits one result per cycle while the output is not stalled, set by the single memory read port.
// Reset empties the table at once; no clearing pass is needed.
// A stalled output holds the sequencer where it emits a result; a new item is taken only when it is idle.
`include "sorted_list_table_engine_core_macros.svh"
module sorted_list_table_engine_core #(
  parameter int unsigned CAPACITY = slte_pkg::DefCapacity
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  slte_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output slte_pkg::rsp_t out_data_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_INS_SH  = 3'd2;
  localparam logic [2:0] S_INS_FIN = 3'd3;
  localparam logic [2:0] S_DEL_SH  = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;
  localparam logic [2:0] S_TRAV    = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic               out_valid_q, out_valid_d;
  slte_pkg::rsp_t     out_q, out_d;
  logic [2:0]         cmd_q, cmd_d;
  logic signed [31:0] val_q, val_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      pos_q, pos_d;
  logic [2:0]         st_q, st_d;
  logic [6:0]         opos_q, opos_d;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic signed [31:0] rdata;

  logic [CW-1:0]      idx_inc;
  logic [CW-1:0]      count_m1;
  logic               out_free;
  logic               trav_last;

  slte_mem #(
    .Depth(CAPACITY),
    .AddrW(IW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(idx_d),
    .rdata_o(rdata)
  );

  assign idx_inc   = CW'(idx_q) + CW'(1);
  assign count_m1  = count_q - CW'(1);
  assign out_free  = !out_valid_q || out_ready_i;
  assign trav_last = (cmd_q == slte_pkg::CmdFwd) ? (idx_inc == count_q) : (idx_q == '0);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_d       = cmd_q;
    val_d       = val_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    st_d        = st_q;
    opos_d      = opos_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = rdata;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = in_data_i.cmd;
          val_d  = in_data_i.value;
          opos_d = '0;
          unique case (in_data_i.cmd)
            slte_pkg::CmdInsert: begin
              if (count_q == CW'(CAPACITY)) begin
                st_d    = slte_pkg::StFull;
                state_d = S_DONE;
              end else if (count_q == '0) begin
                pos_d   = '0;
                state_d = S_INS_FIN;
              end else begin
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            slte_pkg::CmdDelete, slte_pkg::CmdSearch: begin
              if (count_q == '0) begin
                st_d    = slte_pkg::StEmpty;
                state_d = S_DONE;
              end else begin
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            slte_pkg::CmdFwd, slte_pkg::CmdRev: begin
              val_d = '0;
              if (count_q == '0) begin
                st_d    = slte_pkg::StEmpty;
                state_d = S_DONE;
              end else begin
                idx_d   = (in_data_i.cmd == slte_pkg::CmdFwd) ? '0 : count_m1[IW-1:0];
                state_d = S_TRAV;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cmd_q == slte_pkg::CmdInsert) begin
          if (!(rdata < val_q)) begin
            pos_d   = idx_q;
            idx_d   = count_m1[IW-1:0];
            state_d = S_INS_SH;
          end else if (idx_inc == count_q) begin
            pos_d   = count_q[IW-1:0];
            state_d = S_INS_FIN;
          end else begin
            idx_d = idx_inc[IW-1:0];
          end
        end else if (rdata == val_q) begin
          st_d = slte_pkg::StDone;
          if (cmd_q == slte_pkg::CmdSearch) begin
            opos_d  = 7'(idx_inc);
            state_d = S_DONE;
          end else if (idx_inc == count_q) begin
            count_d = count_m1;
            state_d = S_DONE;
          end else begin
            idx_d   = idx_inc[IW-1:0];
            state_d = S_DEL_SH;
          end
        end else if (idx_inc == count_q) begin
          st_d    = slte_pkg::StNotFound;
          state_d = S_DONE;
        end else begin
          idx_d = idx_inc[IW-1:0];
        end
      end
      S_INS_SH: begin
        mem_we    = 1'b1;
        mem_waddr = idx_inc[IW-1:0];
        mem_wdata = rdata;
        if (idx_q == pos_q) begin
          state_d = S_INS_FIN;
        end else begin
          idx_d = idx_q - IW'(1);
        end
      end
      S_INS_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = val_q;
        count_d   = count_q + CW'(1);
        st_d      = slte_pkg::StDone;
        state_d   = S_DONE;
      end
      S_DEL_SH: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q - IW'(1);
        mem_wdata = rdata;
        if (idx_inc == count_q) begin
          count_d = count_m1;
          state_d = S_DONE;
        end else begin
          idx_d = idx_inc[IW-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: st_q, item_value: val_q, position: opos_q, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_TRAV: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: slte_pkg::StEntry, item_value: rdata, position: 7'd0,
                          last: trav_last};
          if (trav_last) begin
            state_d = S_IDLE;
          end else if (cmd_q == slte_pkg::CmdFwd) begin
            idx_d = idx_inc[IW-1:0];
          end else begin
            idx_d = idx_q - IW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    cmd_q  <= cmd_d;
    val_q  <= val_d;
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    st_q   <= st_d;
    opos_q <= opos_d;
  end

  `SLTE_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "Entry count exceeds capacity.")
  `SLTE_ASSERT(a_scan_index, (state_q == S_SCAN) |-> (CW'(idx_q) < count_q),
               "Scan index out of range.")
  `SLTE_ASSERT_NEXT(a_insert_grows, state_q == S_INS_FIN, count_q == $past(count_q) + CW'(1),
                    "Insert did not grow the count.")
  `SLTE_ASSERT(a_write_states,
               mem_we |-> (state_q == S_INS_SH || state_q == S_INS_FIN || state_q == S_DEL_SH),
               "Memory written outside an update.")
  `SLTE_ASSERT(a_trav_nonempty, (state_q == S_TRAV) |-> (count_q != '0),
               "Traverse of an empty table.")

endmodule
